### hdl/cau_pkg.sv
// Shared types, constants and saturation helper for the complex arithmetic unit.
// Depends on nothing; every other file of the block imports it.
package cau_pkg;

  localparam int DW = 32;        // width of one part, signed fixed point
  localparam int FB = 16;        // fraction bits
  localparam int TW = 16;        // tolerance register width
  localparam int FW = 3;         // function code width
  localparam int PW = 2 * DW;    // full product width
  localparam int RW = PW + 1;    // product sum width
  localparam int NW = PW + FB;   // scaled dividend width
  localparam int IW = NW - DW;   // dividend bits above the quotient bits
  localparam int SW = PW + 2;    // common width fed to the saturator
  localparam int QDEPTH = 4;     // queue depth
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [FW-1:0] FUNC_ADD  = FW'(0);
  localparam logic [FW-1:0] FUNC_SUB  = FW'(1);
  localparam logic [FW-1:0] FUNC_MUL  = FW'(2);
  localparam logic [FW-1:0] FUNC_DIV  = FW'(3);
  localparam logic [FW-1:0] FUNC_CONJ = FW'(4);
  localparam logic [FW-1:0] FUNC_CMP  = FW'(5);

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [DW-1:0] re;
    logic [DW-1:0] im;
    logic          eq;
    logic          sat;
    logic          st;
  } res_t;

  typedef struct packed {
    kind_t                kind;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
    res_t                 res;
  } entry_t;

  typedef struct packed {
    logic [DW-1:0] v;
    logic          f;
  } sat_t;

  // clip a wide signed value to the part range
  function automatic sat_t sat_w(input logic signed [SW-1:0] x);
    sat_t r;
    logic  ovf;
    ovf = (x[SW-1:DW-1] != {(SW-DW+1){1'b0}}) && (x[SW-1:DW-1] != {(SW-DW+1){1'b1}});
    r.f = ovf;
    if (!ovf) begin
      r.v = x[DW-1:0];
    end else if (x[SW-1]) begin
      r.v = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r.v = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### hdl/cau_front.sv
// Front end: decodes the function code, finishes add, subtract, conjugate and compare.
// Depends on cau_pkg.
module cau_front import cau_pkg::*; (
  input  logic [FW-1:0]        func,
  input  logic signed [DW-1:0] a_re,
  input  logic signed [DW-1:0] a_im,
  input  logic signed [DW-1:0] b_re,
  input  logic signed [DW-1:0] b_im,
  input  logic [TW-1:0]        tol,
  output entry_t               entry
);

  logic signed [DW:0] add_re, add_im, sub_re, sub_im, neg_im;
  logic [DW:0]        abs_re, abs_im;
  sat_t               s_re, s_im;

  always_comb begin
    add_re = (DW+1)'(a_re) + (DW+1)'(b_re);
    add_im = (DW+1)'(a_im) + (DW+1)'(b_im);
    sub_re = (DW+1)'(a_re) - (DW+1)'(b_re);
    sub_im = (DW+1)'(a_im) - (DW+1)'(b_im);
    neg_im = -(DW+1)'(a_im);
    abs_re = sub_re[DW] ? $unsigned(-sub_re) : $unsigned(sub_re);
    abs_im = sub_im[DW] ? $unsigned(-sub_im) : $unsigned(sub_im);
    s_re   = '0;
    s_im   = '0;

    entry      = '0;
    entry.kind = KIND_SIMPLE;
    entry.a_re = a_re;
    entry.a_im = a_im;
    entry.b_re = b_re;
    entry.b_im = b_im;

    unique case (func)
      FUNC_ADD: begin
        s_re = sat_w(SW'(add_re));
        s_im = sat_w(SW'(add_im));
        entry.res.re  = s_re.v;
        entry.res.im  = s_im.v;
        entry.res.sat = s_re.f | s_im.f;
      end
      FUNC_SUB: begin
        s_re = sat_w(SW'(sub_re));
        s_im = sat_w(SW'(sub_im));
        entry.res.re  = s_re.v;
        entry.res.im  = s_im.v;
        entry.res.sat = s_re.f | s_im.f;
      end
      FUNC_MUL: entry.kind = KIND_MUL;
      FUNC_DIV: entry.kind = KIND_DIV;
      FUNC_CONJ: begin
        s_im = sat_w(SW'(neg_im));
        entry.res.re  = a_re;
        entry.res.im  = s_im.v;
        entry.res.sat = s_im.f;
      end
      FUNC_CMP: begin
        entry.res.eq = (abs_re < (DW+1)'(tol)) && (abs_im < (DW+1)'(tol));
      end
      default: entry.res = '0;
    endcase
  end

endmodule

### hdl/cau_fifo.sv
// Short queue of decoded words between the front end and the arithmetic pipeline.
// Depends on cau_pkg.
module cau_fifo import cau_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  entry_t wr_data,
  output logic   rd_valid,
  input  logic   rd_ready,
  output entry_t rd_data
);

  entry_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           do_wr, do_rd;

  assign wr_ready = (count != (QAW+1)'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

### hdl/cau_back.sv
// Back end: multiply, sum, scale stages, pipelined restoring divider, output register.
// Depends on cau_pkg.
module cau_back import cau_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  entry_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_data
);

  typedef struct packed {
    kind_t         kind;
    res_t          res;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic          big_re;
    logic          big_im;
    logic [PW-1:0] rem_re;
    logic [PW-1:0] rem_im;
    logic [DW-1:0] q_re;
    logic [DW-1:0] q_im;
    logic [DW-1:0] lo_re;
    logic [DW-1:0] lo_im;
    logic [PW-1:0] den;
  } dstage_t;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 0: operands
  logic   v0;
  entry_t e0;
  // stage 1: products
  logic                 v1;
  kind_t                k1;
  res_t                 r1;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  // stage 2: sums
  logic                 v2;
  kind_t                k2;
  res_t                 r2;
  logic signed [RW-1:0] m_re, m_im, d_re, d_im;
  logic [PW-1:0]        den2;
  // stage 3: magnitudes and product scaling and clipping
  logic                 v3;
  kind_t                k3;
  res_t                 r3;
  logic [NW-1:0]        num_re, num_im;
  logic                 ng_re, ng_im, dz3;
  logic [PW-1:0]        den3;
  // divider stages
  logic                 dv [DW+1];
  dstage_t              ds [DW+1];

  logic signed [RW-1:0] sh_re, sh_im;
  logic [RW-1:0]        ab_re, ab_im;
  sat_t                 ms_re, ms_im;
  res_t                 r3_next;

  always_comb begin
    sh_re = m_re >>> FB;
    sh_im = m_im >>> FB;
    ms_re = sat_w(SW'(sh_re));
    ms_im = sat_w(SW'(sh_im));
    ab_re = d_re[RW-1] ? $unsigned(-d_re) : $unsigned(d_re);
    ab_im = d_im[RW-1] ? $unsigned(-d_im) : $unsigned(d_im);
    r3_next = r2;
    if (k2 == KIND_MUL) begin
      r3_next.re  = ms_re.v;
      r3_next.im  = ms_im.v;
      r3_next.sat = ms_re.f | ms_im.f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      dv[0] <= 1'b0;
    end else if (adv) begin
      v0    <= in_valid;
      v1    <= v0;
      v2    <= v1;
      v3    <= v2;
      dv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e0 <= in_data;

      k1   <= e0.kind;
      r1   <= e0.res;
      p_rr <= e0.a_re * e0.b_re;
      p_ii <= e0.a_im * e0.b_im;
      p_ri <= e0.a_re * e0.b_im;
      p_ir <= e0.a_im * e0.b_re;
      p_bb <= e0.b_re * e0.b_re;
      p_cc <= e0.b_im * e0.b_im;

      k2   <= k1;
      r2   <= r1;
      m_re <= RW'(p_rr) - RW'(p_ii);
      m_im <= RW'(p_ri) + RW'(p_ir);
      d_re <= RW'(p_rr) + RW'(p_ii);
      d_im <= RW'(p_ir) - RW'(p_ri);
      den2 <= $unsigned(p_bb) + $unsigned(p_cc);

      k3     <= k2;
      r3     <= r3_next;
      num_re <= {ab_re[PW-1:0], {FB{1'b0}}};
      num_im <= {ab_im[PW-1:0], {FB{1'b0}}};
      ng_re  <= d_re[RW-1];
      ng_im  <= d_im[RW-1];
      den3   <= den2;
      dz3    <= (den2 == '0);

      ds[0].kind   <= k3;
      ds[0].res    <= r3;
      ds[0].dz     <= dz3;
      ds[0].neg_re <= ng_re;
      ds[0].neg_im <= ng_im;
      ds[0].big_re <= (PW'(num_re[NW-1:DW]) >= den3);
      ds[0].big_im <= (PW'(num_im[NW-1:DW]) >= den3);
      ds[0].rem_re <= PW'(num_re[NW-1:DW]);
      ds[0].rem_im <= PW'(num_im[NW-1:DW]);
      ds[0].q_re   <= '0;
      ds[0].q_im   <= '0;
      ds[0].lo_re  <= num_re[DW-1:0];
      ds[0].lo_im  <= num_im[DW-1:0];
      ds[0].den    <= den3;
    end
  end

  // one quotient bit per stage for both parts
  for (genvar i = 0; i < DW; i++) begin : g_div
    logic [RW-1:0] t_re, t_im, dd;
    logic          b_re, b_im;
    dstage_t       ds_next;
    always_comb begin
      dd   = {1'b0, ds[i].den};
      t_re = {ds[i].rem_re, ds[i].lo_re[DW-1]};
      t_im = {ds[i].rem_im, ds[i].lo_im[DW-1]};
      b_re = (t_re >= dd);
      b_im = (t_im >= dd);
      ds_next        = ds[i];
      ds_next.rem_re = b_re ? PW'(t_re - dd) : t_re[PW-1:0];
      ds_next.rem_im = b_im ? PW'(t_im - dd) : t_im[PW-1:0];
      ds_next.q_re   = {ds[i].q_re[DW-2:0], b_re};
      ds_next.q_im   = {ds[i].q_im[DW-2:0], b_im};
      ds_next.lo_re  = {ds[i].lo_re[DW-2:0], 1'b0};
      ds_next.lo_im  = {ds[i].lo_im[DW-2:0], 1'b0};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (adv) begin
        dv[i+1] <= dv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ds[i+1] <= ds_next;
      end
    end
  end

  // quotient sign and clipping
  dstage_t       fin;
  res_t          res_next;
  logic [DW-1:0] lim_re, lim_im;
  logic          ov_re, ov_im;

  always_comb begin
    fin    = ds[DW];
    lim_re = fin.neg_re ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    lim_im = fin.neg_im ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    ov_re  = fin.big_re || (fin.q_re > lim_re);
    ov_im  = fin.big_im || (fin.q_im > lim_im);
    res_next = fin.res;
    if (fin.kind == KIND_DIV) begin
      res_next = '0;
      if (fin.dz) begin
        res_next.st = 1'b1;
      end else begin
        res_next.re  = ov_re ? lim_re : (fin.neg_re ? -fin.q_re : fin.q_re);
        res_next.im  = ov_im ? lim_im : (fin.neg_im ? -fin.q_im : fin.q_im);
        res_next.sat = ov_re | ov_im;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data <= res_next;
  end

endmodule

### hdl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide, conjugate, compare on Q16.16.
// One word per cycle sustained while m_axis_tready does not stall the output, through
// the one-bit-per-stage divider pipeline that all words pass.
// Reset is synchronous: clears the queue, the stage valid bits and sets tolerance to 7.
// Depends on cau_pkg, cau_front, cau_fifo and cau_back.
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // configuration: equal_tolerance
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TW-1:0]    cfg_data,
  // input words
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [4*DW-1:0]  s_axis_tdata,  // a_re, a_im, b_re, b_im
  input  logic [FW-1:0]    s_axis_tuser,  // func
  // result words
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [2*DW-1:0]  m_axis_tdata,  // result_re, result_im
  output logic [2:0]       m_axis_tuser   // equal_flag, saturated, status
);

  logic [TW-1:0] tol;
  entry_t        dec, q_data;
  logic          q_valid, q_ready;
  res_t          res;

  // tolerance register; always ready, a write applies to words decoded after it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TW'(7);
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end

  // classify and finish the cheap operations on the way in
  cau_front u_front (
    .func  (s_axis_tuser),
    .a_re  (s_axis_tdata[DW-1:0]),
    .a_im  (s_axis_tdata[2*DW-1:DW]),
    .b_re  (s_axis_tdata[3*DW-1:2*DW]),
    .b_im  (s_axis_tdata[4*DW-1:3*DW]),
    .tol   (tol),
    .entry (dec)
  );

  // queue decouples acceptance from pipeline stalls
  cau_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (s_axis_tvalid),
    .wr_ready (s_axis_tready),
    .wr_data  (dec),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // multiply and divide, with the other results riding along to keep order
  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_data   (q_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = {res.im, res.re};
  assign m_axis_tuser = {res.st, res.sat, res.eq};

endmodule
